// ===== rtl/event_latch_dependency_release_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Event latch dependency release unit: assertion macros
// Concurrent assertion helpers, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_LATCH_DEPENDENCY_RELEASE_UNIT_DEFINES_SVH
`define EVENT_LATCH_DEPENDENCY_RELEASE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ELDRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELDRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/eldru_pkg.sv =====
// ----------------------------------------------------------------------------
// eldru_pkg
// Types and constants shared by the event latch dependency release unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eldru_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAIR,
    ST_DRAIN
  } state_t;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 4'd1;

  localparam logic [1:0] STATUS_DELIVERY = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [1:0] KIND_EVENT = 2'd1;

  localparam logic        REQ_SATISFY   = 1'b0;
  localparam logic [31:0] SLOT_DECREMENT = 32'd0;
  localparam logic [31:0] SLOT_INCREMENT = 32'd1;

  typedef struct packed {
    logic [63:0] target;
    logic [31:0] slot;
    logic [3:0]  mode;
    logic [1:0]  kind;
  } dep_entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] target;
    logic        kind;
    logic [31:0] slot;
    logic [3:0]  mode;
    logic [63:0] data;
    logic        last;
  } result_t;

  function automatic result_t make_result(input logic [1:0] status,
                                          input dep_entry_t entry,
                                          input logic [63:0] data,
                                          input logic last);
    result_t r;
    r.status = status;
    r.target = entry.target;
    r.kind   = entry.kind[0];
    r.slot   = entry.slot;
    r.mode   = entry.mode;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  function automatic result_t error_result(input logic [1:0] status);
    result_t r;
    r        = '0;
    r.status = status;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/event_latch_dependency_release_unit.sv =====
// ----------------------------------------------------------------------------
// Event latch dependency release unit
// One synchronisation event, run as a counting latch or as a channel that
// pairs data words with queued dependents, with both queues held in RAM.
// ----------------------------------------------------------------------------
// Channel  Handshake              Word
// in_      start / busy           request: type, slot, data, target, kind, mode
// out_     out_valid strobe       result: status, target, kind, slot, mode, data
// cfg_     cfg_valid / cfg_ready  register index and data
//
// A latch request or an error is handled in idle; its result, if any, appears
// in the following cycle. A channel request that pairs reads the queue RAM and
// holds busy in the pair state; its result is registered from the read word.
// A firing decrement holds busy in the drain state while it drains the queued
// dependents, one RAM read a cycle. Reset is synchronous. Results cannot be
// stalled: each strobe lasts one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "event_latch_dependency_release_unit_defines.svh"

module event_latch_dependency_release_unit #(
  parameter int unsigned DEP_DEPTH  = 32,
  parameter int unsigned DATA_DEPTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 in_req_type,
  input  wire  [31:0]                         in_slot,
  input  wire  [63:0]                         in_data_id,
  input  wire  [63:0]                         in_target_id,
  input  wire  [1:0]                          in_target_kind,
  input  wire  [3:0]                          in_dep_mode,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [63:0]                         out_target,
  output logic                                out_kind,
  output logic [31:0]                         out_slot,
  output logic [3:0]                          out_mode,
  output logic [63:0]                         out_data,
  output logic                                out_last,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [eldru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [15:0]                         cfg_data
);

  localparam int unsigned DAW = (DEP_DEPTH > 1) ? $clog2(DEP_DEPTH) : 1;
  localparam int unsigned DCW = $clog2(DEP_DEPTH + 1);
  localparam int unsigned DSW = DCW + 1;
  localparam int unsigned AAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned ACW = $clog2(DATA_DEPTH + 1);
  localparam int unsigned ASW = ACW + 1;

  localparam logic [DAW-1:0] DEP_LAST  = DAW'(DEP_DEPTH - 1);
  localparam logic [DCW-1:0] DEP_FULL  = DCW'(DEP_DEPTH);
  localparam logic [DSW-1:0] DEP_WRAP  = DSW'(DEP_DEPTH);
  localparam logic [AAW-1:0] DAT_LAST  = AAW'(DATA_DEPTH - 1);
  localparam logic [ACW-1:0] DAT_FULL  = ACW'(DATA_DEPTH);
  localparam logic [ASW-1:0] DAT_WRAP  = ASW'(DATA_DEPTH);

  eldru_pkg::state_t     state_r, state_nxt;
  logic                  channel_mode_r, channel_mode_nxt;
  logic [15:0]           initial_count_r, initial_count_nxt;
  logic [31:0]           latch_count_r, latch_count_nxt;
  logic                  fired_r, fired_nxt;
  logic [63:0]           stored_data_r, stored_data_nxt;
  logic [DAW-1:0]        dep_head_r, dep_head_nxt;
  logic [DCW-1:0]        dep_cnt_r, dep_cnt_nxt;
  logic [AAW-1:0]        dat_head_r, dat_head_nxt;
  logic [ACW-1:0]        dat_cnt_r, dat_cnt_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic                  hold_valid_r, hold_valid_nxt;
  eldru_pkg::dep_entry_t hold_r, hold_nxt;
  logic                  pend_is_dep_r, pend_is_dep_nxt;
  eldru_pkg::dep_entry_t pend_dep_r, pend_dep_nxt;
  logic [63:0]           pend_data_r, pend_data_nxt;
  logic                  out_valid_r, out_valid_nxt;
  eldru_pkg::result_t    res_r, res_nxt;

  eldru_pkg::dep_entry_t dep_mem [DEP_DEPTH];
  logic [63:0]           dat_mem [DATA_DEPTH];
  eldru_pkg::dep_entry_t dep_rdata_r;
  logic [63:0]           dat_rdata_r;

  logic                  dep_we, dep_re, dat_we, dat_re;
  logic [DSW-1:0]        dep_tail_sum;
  logic [ASW-1:0]        dat_tail_sum;
  logic [DAW-1:0]        dep_tail;
  logic [AAW-1:0]        dat_tail;
  logic [DAW-1:0]        dep_head_inc;
  logic [AAW-1:0]        dat_head_inc;
  eldru_pkg::dep_entry_t in_entry;
  eldru_pkg::dep_entry_t pair_entry;
  logic [63:0]           pair_data;
  logic                  accept;
  logic                  cfg_write;

  assign busy      = (state_r != eldru_pkg::ST_IDLE);
  assign cfg_ready = (state_r == eldru_pkg::ST_IDLE) && !start;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready &&
                     ((cfg_index == eldru_pkg::CFG_CHANNEL_MODE) ||
                      (cfg_index == eldru_pkg::CFG_INITIAL_COUNT));

  assign out_valid  = out_valid_r;
  assign out_status = res_r.status;
  assign out_target = res_r.target;
  assign out_kind   = res_r.kind;
  assign out_slot   = res_r.slot;
  assign out_mode   = res_r.mode;
  assign out_data   = res_r.data;
  assign out_last   = res_r.last;

  assign dep_tail_sum = DSW'(dep_head_r) + DSW'(dep_cnt_r);
  assign dat_tail_sum = ASW'(dat_head_r) + ASW'(dat_cnt_r);
  assign dep_tail = (dep_tail_sum >= DEP_WRAP) ? DAW'(dep_tail_sum - DEP_WRAP)
                                               : DAW'(dep_tail_sum);
  assign dat_tail = (dat_tail_sum >= DAT_WRAP) ? AAW'(dat_tail_sum - DAT_WRAP)
                                               : AAW'(dat_tail_sum);
  assign dep_head_inc = (dep_head_r == DEP_LAST) ? '0 : dep_head_r + DAW'(1);
  assign dat_head_inc = (dat_head_r == DAT_LAST) ? '0 : dat_head_r + AAW'(1);

  assign in_entry.target = in_target_id;
  assign in_entry.slot   = in_slot;
  assign in_entry.mode   = in_dep_mode;
  assign in_entry.kind   = in_target_kind;

  assign pair_entry = pend_is_dep_r ? pend_dep_r : dep_rdata_r;
  assign pair_data  = pend_is_dep_r ? dat_rdata_r : pend_data_r;

  always_comb begin
    state_nxt         = state_r;
    channel_mode_nxt  = channel_mode_r;
    initial_count_nxt = initial_count_r;
    latch_count_nxt   = latch_count_r;
    fired_nxt         = fired_r;
    stored_data_nxt   = stored_data_r;
    dep_head_nxt      = dep_head_r;
    dep_cnt_nxt       = dep_cnt_r;
    dat_head_nxt      = dat_head_r;
    dat_cnt_nxt       = dat_cnt_r;
    rd_valid_nxt      = 1'b0;
    hold_valid_nxt    = hold_valid_r;
    hold_nxt          = hold_r;
    pend_is_dep_nxt   = pend_is_dep_r;
    pend_dep_nxt      = pend_dep_r;
    pend_data_nxt     = pend_data_r;
    out_valid_nxt     = 1'b0;
    res_nxt           = res_r;
    dep_we            = 1'b0;
    dep_re            = 1'b0;
    dat_we            = 1'b0;
    dat_re            = 1'b0;

    case (state_r)
      eldru_pkg::ST_IDLE: begin
        if (cfg_write) begin
          if (cfg_index == eldru_pkg::CFG_CHANNEL_MODE) begin
            channel_mode_nxt = cfg_data[0];
            latch_count_nxt  = {16'd0, initial_count_r};
          end else begin
            initial_count_nxt = cfg_data;
            latch_count_nxt   = {16'd0, cfg_data};
          end
          fired_nxt       = 1'b0;
          stored_data_nxt = '0;
          dep_head_nxt    = '0;
          dep_cnt_nxt     = '0;
          dat_head_nxt    = '0;
          dat_cnt_nxt     = '0;
        end else if (accept) begin
          if (channel_mode_r) begin
            if (in_req_type == eldru_pkg::REQ_SATISFY) begin
              if (in_slot != eldru_pkg::SLOT_DECREMENT) begin
                out_valid_nxt = 1'b1;
                res_nxt       = eldru_pkg::error_result(eldru_pkg::STATUS_INVALID);
              end else if (dat_cnt_r == DAT_FULL) begin
                out_valid_nxt = 1'b1;
                res_nxt       = eldru_pkg::error_result(eldru_pkg::STATUS_FULL);
              end else if (dep_cnt_r != '0) begin
                dep_re          = 1'b1;
                dep_head_nxt    = dep_head_inc;
                dep_cnt_nxt     = dep_cnt_r - DCW'(1);
                pend_is_dep_nxt = 1'b0;
                pend_data_nxt   = in_data_id;
                state_nxt       = eldru_pkg::ST_PAIR;
              end else begin
                dat_we      = 1'b1;
                dat_cnt_nxt = dat_cnt_r + ACW'(1);
              end
            end else begin
              if (dep_cnt_r == DEP_FULL) begin
                out_valid_nxt = 1'b1;
                res_nxt       = eldru_pkg::error_result(eldru_pkg::STATUS_FULL);
              end else if (dat_cnt_r != '0) begin
                dat_re          = 1'b1;
                dat_head_nxt    = dat_head_inc;
                dat_cnt_nxt     = dat_cnt_r - ACW'(1);
                pend_is_dep_nxt = 1'b1;
                pend_dep_nxt    = in_entry;
                state_nxt       = eldru_pkg::ST_PAIR;
              end else begin
                dep_we      = 1'b1;
                dep_cnt_nxt = dep_cnt_r + DCW'(1);
              end
            end
          end else if (in_req_type == eldru_pkg::REQ_SATISFY) begin
            if (in_slot == eldru_pkg::SLOT_INCREMENT) begin
              latch_count_nxt = latch_count_r + 32'd1;
            end else if (in_slot == eldru_pkg::SLOT_DECREMENT) begin
              latch_count_nxt = latch_count_r - 32'd1;
              if (latch_count_r == 32'd1) begin
                fired_nxt = 1'b1;
                if (in_data_id != '0) begin
                  stored_data_nxt = in_data_id;
                end
                if (dep_cnt_r != '0) begin
                  hold_valid_nxt = 1'b0;
                  state_nxt      = eldru_pkg::ST_DRAIN;
                end
              end
            end else begin
              out_valid_nxt = 1'b1;
              res_nxt       = eldru_pkg::error_result(eldru_pkg::STATUS_INVALID);
            end
          end else begin
            if (fired_r) begin
              if (in_target_kind <= eldru_pkg::KIND_EVENT) begin
                out_valid_nxt = 1'b1;
                res_nxt       = eldru_pkg::make_result(eldru_pkg::STATUS_DELIVERY,
                                                       in_entry, stored_data_r, 1'b1);
              end
            end else if (dep_cnt_r == DEP_FULL) begin
              out_valid_nxt = 1'b1;
              res_nxt       = eldru_pkg::error_result(eldru_pkg::STATUS_FULL);
            end else begin
              dep_we      = 1'b1;
              dep_cnt_nxt = dep_cnt_r + DCW'(1);
            end
          end
        end
      end

      eldru_pkg::ST_PAIR: begin
        if (pair_entry.kind <= eldru_pkg::KIND_EVENT) begin
          out_valid_nxt = 1'b1;
          res_nxt       = eldru_pkg::make_result(eldru_pkg::STATUS_DELIVERY,
                                                 pair_entry, pair_data, 1'b1);
        end
        state_nxt = eldru_pkg::ST_IDLE;
      end

      eldru_pkg::ST_DRAIN: begin
        if (dep_cnt_r != '0) begin
          dep_re       = 1'b1;
          rd_valid_nxt = 1'b1;
          dep_head_nxt = dep_head_inc;
          dep_cnt_nxt  = dep_cnt_r - DCW'(1);
        end
        if (rd_valid_r && (dep_rdata_r.kind <= eldru_pkg::KIND_EVENT)) begin
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            res_nxt       = eldru_pkg::make_result(eldru_pkg::STATUS_DELIVERY,
                                                   hold_r, stored_data_r, 1'b0);
          end
          hold_nxt       = dep_rdata_r;
          hold_valid_nxt = 1'b1;
        end
        if ((dep_cnt_r == '0) && !rd_valid_r) begin
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            res_nxt       = eldru_pkg::make_result(eldru_pkg::STATUS_DELIVERY,
                                                   hold_r, stored_data_r, 1'b1);
          end
          hold_valid_nxt = 1'b0;
          state_nxt      = eldru_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = eldru_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= eldru_pkg::ST_IDLE;
      channel_mode_r  <= 1'b0;
      initial_count_r <= 16'd1;
      latch_count_r   <= 32'd1;
      fired_r         <= 1'b0;
      stored_data_r   <= '0;
      dep_head_r      <= '0;
      dep_cnt_r       <= '0;
      dat_head_r      <= '0;
      dat_cnt_r       <= '0;
      rd_valid_r      <= 1'b0;
      hold_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      channel_mode_r  <= channel_mode_nxt;
      initial_count_r <= initial_count_nxt;
      latch_count_r   <= latch_count_nxt;
      fired_r         <= fired_nxt;
      stored_data_r   <= stored_data_nxt;
      dep_head_r      <= dep_head_nxt;
      dep_cnt_r       <= dep_cnt_nxt;
      dat_head_r      <= dat_head_nxt;
      dat_cnt_r       <= dat_cnt_nxt;
      rd_valid_r      <= rd_valid_nxt;
      hold_valid_r    <= hold_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r        <= hold_nxt;
    pend_is_dep_r <= pend_is_dep_nxt;
    pend_dep_r    <= pend_dep_nxt;
    pend_data_r   <= pend_data_nxt;
    res_r         <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_tail] <= in_entry;
    end
    if (dep_re) begin
      dep_rdata_r <= dep_mem[dep_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (dat_we) begin
      dat_mem[dat_tail] <= in_data_id;
    end
    if (dat_re) begin
      dat_rdata_r <= dat_mem[dat_head_r];
    end
  end

  `ELDRU_ASSERT_NOW(a_chan_one_queue_empty,
    (state_r == eldru_pkg::ST_IDLE) && channel_mode_r,
    (dep_cnt_r == '0) || (dat_cnt_r == '0),
    "Channel mode holds both data and dependents while idle.")

  `ELDRU_ASSERT_NOW(a_fired_queue_empty,
    (state_r == eldru_pkg::ST_IDLE) && !channel_mode_r && fired_r,
    dep_cnt_r == '0,
    "Fired latch still holds queued dependents.")

  `ELDRU_ASSERT_NOW(a_error_is_last,
    out_valid && (out_status != eldru_pkg::STATUS_DELIVERY),
    out_last,
    "Error result not marked as last.")

  `ELDRU_ASSERT_NEXT(a_drain_ends_idle,
    (state_r == eldru_pkg::ST_DRAIN) && (dep_cnt_r == '0) && !rd_valid_r,
    state_r == eldru_pkg::ST_IDLE,
    "Drain did not return to idle once the queue emptied.")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the event latch dependency release unit. Request
// words are driven through the start/busy handshake and an in-bench model of
// the latch and channel behaviour predicts every result word. Each result word
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEP_DEPTH     = 32;
  localparam int unsigned DATA_DEPTH    = 32;
  localparam int unsigned SETTLE_CYCLES = DEP_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT   = 100000;

  localparam logic       REQ_DEPENDENT = 1'b1;
  localparam logic [1:0] KIND_TASK     = 2'd0;
  localparam logic [1:0] KIND_OTHER    = 2'd2;
  localparam logic [1:0] KIND_SPARE    = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [31:0] slot;
    logic [63:0] data_id;
    logic [63:0] target_id;
    logic [1:0]  target_kind;
    logic [3:0]  dep_mode;
  } req_word_t;

  logic                            clk            = 1'b0;
  logic                            rst_n          = 1'b0;
  logic                            start          = 1'b0;
  logic                            in_req_type    = 1'b0;
  logic [31:0]                     in_slot        = '0;
  logic [63:0]                     in_data_id     = '0;
  logic [63:0]                     in_target_id   = '0;
  logic [1:0]                      in_target_kind = '0;
  logic [3:0]                      in_dep_mode    = '0;
  logic                            cfg_valid      = 1'b0;
  logic [eldru_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
  logic [15:0]                     cfg_data       = '0;
  logic                            busy;
  logic                            cfg_ready;
  logic                            out_valid;
  logic [1:0]                      out_status;
  logic [63:0]                     out_target;
  logic                            out_kind;
  logic [31:0]                     out_slot;
  logic [3:0]                      out_mode;
  logic [63:0]                     out_data;
  logic                            out_last;

  logic                  chan_mode   = 1'b0;
  logic [15:0]           init_count  = 16'd1;
  logic [31:0]           latch_count = 32'd1;
  logic                  latch_fired = 1'b0;
  logic [63:0]           held_data   = '0;
  eldru_pkg::dep_entry_t waiting_deps[$];
  logic [63:0]           pending_data[$];
  eldru_pkg::result_t    expected_results[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          pace_on     = 1'b1;
  int unsigned burst_left  = 1;

  event_latch_dependency_release_unit #(
    .DEP_DEPTH (DEP_DEPTH),
    .DATA_DEPTH(DATA_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_slot       (in_slot),
    .in_data_id    (in_data_id),
    .in_target_id  (in_target_id),
    .in_target_kind(in_target_kind),
    .in_dep_mode   (in_dep_mode),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_target    (out_target),
    .out_kind      (out_kind),
    .out_slot      (out_slot),
    .out_mode      (out_mode),
    .out_data      (out_data),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("event_latch_dependency_release_unit test failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] bad_slot(input logic [31:0] lowest);
    logic [31:0] s;
    s = $urandom();
    return (s < lowest) ? lowest : s;
  endfunction

  function automatic req_word_t dep_word(input logic [1:0] kind);
    req_word_t w;
    w.req_type    = REQ_DEPENDENT;
    w.slot        = $urandom();
    w.data_id     = rand64();
    w.target_id   = rand64();
    w.target_kind = kind;
    w.dep_mode    = 4'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic req_word_t satisfy_word(input logic [31:0] slot, input logic [63:0] data);
    req_word_t w;
    w          = dep_word(2'($urandom_range(0, 3)));
    w.req_type = eldru_pkg::REQ_SATISFY;
    w.slot     = slot;
    w.data_id  = data;
    return w;
  endfunction

  function automatic eldru_pkg::result_t delivery(input eldru_pkg::dep_entry_t d,
                                                  input logic [63:0] dv);
    eldru_pkg::result_t r;
    r.status = eldru_pkg::STATUS_DELIVERY;
    r.target = d.target;
    r.kind   = d.kind[0];
    r.slot   = d.slot;
    r.mode   = d.mode;
    r.data   = dv;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic eldru_pkg::result_t fault(input logic [1:0] status);
    eldru_pkg::result_t r;
    r        = '0;
    r.status = status;
    return r;
  endfunction

  // Works out the result words that one accepted request word causes.
  task automatic predict_release(input req_word_t w);
    eldru_pkg::result_t    produced[$];
    eldru_pkg::dep_entry_t d;
    logic [63:0]           dv;
    d.target = w.target_id;
    d.slot   = w.slot;
    d.mode   = w.dep_mode;
    d.kind   = w.target_kind;
    if (chan_mode) begin
      if (w.req_type == eldru_pkg::REQ_SATISFY) begin
        if (w.slot != eldru_pkg::SLOT_DECREMENT) begin
          produced.push_back(fault(eldru_pkg::STATUS_INVALID));
        end else if (pending_data.size() >= DATA_DEPTH) begin
          produced.push_back(fault(eldru_pkg::STATUS_FULL));
        end else begin
          pending_data.push_back(w.data_id);
        end
      end else if (waiting_deps.size() >= DEP_DEPTH) begin
        produced.push_back(fault(eldru_pkg::STATUS_FULL));
      end else begin
        waiting_deps.push_back(d);
      end
      while (pending_data.size() > 0 && waiting_deps.size() > 0 &&
             produced.size() < DEP_DEPTH) begin
        dv = pending_data.pop_front();
        d  = waiting_deps.pop_front();
        if (d.kind <= eldru_pkg::KIND_EVENT) produced.push_back(delivery(d, dv));
      end
    end else if (w.req_type == eldru_pkg::REQ_SATISFY) begin
      if (w.slot == eldru_pkg::SLOT_INCREMENT) begin
        latch_count = latch_count + 32'd1;
      end else if (w.slot == eldru_pkg::SLOT_DECREMENT) begin
        latch_count = latch_count - 32'd1;
        // Only a decrement from exactly one fires the event.
        if (latch_count == 32'd0) begin
          if (w.data_id != '0) held_data = w.data_id;
          latch_fired = 1'b1;
          while (waiting_deps.size() > 0) begin
            d = waiting_deps.pop_front();
            if (d.kind <= eldru_pkg::KIND_EVENT) produced.push_back(delivery(d, held_data));
          end
        end
      end else begin
        produced.push_back(fault(eldru_pkg::STATUS_INVALID));
      end
    end else if (latch_fired) begin
      if (d.kind <= eldru_pkg::KIND_EVENT) produced.push_back(delivery(d, held_data));
    end else if (waiting_deps.size() >= DEP_DEPTH) begin
      produced.push_back(fault(eldru_pkg::STATUS_FULL));
    end else begin
      waiting_deps.push_back(d);
    end
    if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
    foreach (produced[i]) expected_results.push_back(produced[i]);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    eldru_pkg::result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result word with none expected: status %0d, target %0h", out_status,
               out_target);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("out_target", want.target, out_target);
        check_field("out_kind", 64'(want.kind), 64'(out_kind));
        check_field("out_slot", 64'(want.slot), 64'(out_slot));
        check_field("out_mode", 64'(want.mode), 64'(out_mode));
        check_field("out_data", want.data, out_data);
        check_field("last", 64'(want.last), 64'(out_last));
      end
    end
  end

  // Sends one request word and, when pacing is on, closes a burst with a gap.
  task automatic send_word(input req_word_t w);
    @(negedge clk);
    start          <= 1'b1;
    in_req_type    <= w.req_type;
    in_slot        <= w.slot;
    in_data_id     <= w.data_id;
    in_target_id   <= w.target_id;
    in_target_kind <= w.target_kind;
    in_dep_mode    <= w.dep_mode;
    do @(posedge clk); while (busy !== 1'b0);
    predict_release(w);
    if (pace_on) begin
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          start <= 1'b0;
        end
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Any register write reloads the count and empties both stores.
  task automatic write_register(input logic [eldru_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == eldru_pkg::CFG_CHANNEL_MODE) chan_mode = value[0];
    else init_count = value;
    latch_count = {16'd0, init_count};
    latch_fired = 1'b0;
    held_data   = '0;
    waiting_deps.delete();
    pending_data.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_latch_directed();
    req_word_t w;
    pace_on       = 1'b1;
    w             = dep_word(KIND_TASK);
    w.target_id   = '1;
    w.slot        = '1;
    w.dep_mode    = 4'hF;
    send_word(w);
    w             = dep_word(eldru_pkg::KIND_EVENT);
    w.target_id   = '0;
    w.slot        = '0;
    w.dep_mode    = 4'h0;
    send_word(w);
    send_word(dep_word(KIND_OTHER));
    send_word(dep_word(KIND_SPARE));
    send_word(satisfy_word('1, rand64()));
    send_word(satisfy_word(32'd2, rand64()));
    send_word(satisfy_word(eldru_pkg::SLOT_INCREMENT, '0));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, rand64()));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, '1));
    send_word(dep_word(KIND_TASK));
    send_word(dep_word(KIND_SPARE));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, rand64()));
    send_word(satisfy_word(eldru_pkg::SLOT_INCREMENT, rand64()));
    send_word(satisfy_word(eldru_pkg::SLOT_INCREMENT, rand64()));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, '0));
    send_word(dep_word(eldru_pkg::KIND_EVENT));
    send_word(satisfy_word(eldru_pkg::SLOT_INCREMENT, '0));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, 64'h5A5A_0F0F_C3C3_9696));
    send_word(dep_word(KIND_TASK));
  endtask

  task automatic test_channel_directed();
    req_word_t w;
    write_register(eldru_pkg::CFG_CHANNEL_MODE, 16'd1);
    send_word(satisfy_word(eldru_pkg::SLOT_INCREMENT, rand64()));
    send_word(satisfy_word('1, rand64()));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, '1));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, '0));
    w             = dep_word(KIND_TASK);
    w.target_id   = '1;
    w.slot        = '1;
    w.dep_mode    = 4'hF;
    send_word(w);
    send_word(dep_word(KIND_OTHER));
    w             = dep_word(eldru_pkg::KIND_EVENT);
    w.target_id   = '0;
    w.slot        = '0;
    w.dep_mode    = 4'h0;
    send_word(w);
    send_word(dep_word(KIND_SPARE));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, rand64()));
    send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, rand64()));
  endtask

  task automatic test_latch_random();
    logic [15:0] counts[4] = '{16'hFFFF, 16'd3, 16'd2, 16'd1};
    int unsigned n_deps;
    int unsigned pick;
    write_register(eldru_pkg::CFG_CHANNEL_MODE, 16'd0);
    for (int round = 0; round < 4; round++) begin
      write_register(eldru_pkg::CFG_INITIAL_COUNT, counts[round]);
      pace_on = (round != 2);
      n_deps  = (round == 3) ? DEP_DEPTH + 1 : $urandom_range(0, 2);
      repeat (n_deps) send_word(dep_word(2'($urandom_range(0, 3))));
      for (int k = 0; k < 4 && !latch_fired; k++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          send_word(satisfy_word(eldru_pkg::SLOT_INCREMENT, rand64()));
        end else if (pick == 1) begin
          send_word(satisfy_word(bad_slot(32'd2), rand64()));
        end else begin
          send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, (pick == 2) ? '0 : rand64()));
        end
      end
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 3) == 0) begin
          send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, rand64()));
        end else begin
          send_word(dep_word(2'($urandom_range(0, 3))));
        end
      end
      if (round == 1) wait_drained();
    end
  endtask

  task automatic test_channel_random();
    int unsigned pick;
    write_register(eldru_pkg::CFG_CHANNEL_MODE, 16'd1);
    write_register(eldru_pkg::CFG_INITIAL_COUNT, 16'($urandom_range(0, 16'hFFFF)));
    for (int round = 0; round < 2; round++) begin
      if (round > 0) write_register(eldru_pkg::CFG_CHANNEL_MODE, 16'd1);
      pace_on = (round != 0);
      if (round == 1) begin
        repeat (DATA_DEPTH + 1) send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, rand64()));
      end
      repeat ((round == 0) ? 6 : 4) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_word(satisfy_word(bad_slot(32'd1), rand64()));
        end else if (pick < 5) begin
          send_word(satisfy_word(eldru_pkg::SLOT_DECREMENT, rand64()));
        end else begin
          send_word(dep_word(2'($urandom_range(0, 3))));
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_latch_directed();
    test_channel_directed();
    test_latch_random();
    test_channel_random();
    wait_drained();
    if (error_count == 0) begin
      $display("event_latch_dependency_release_unit test passed");
    end else begin
      $display("event_latch_dependency_release_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/eldru_pkg.sv
rtl/event_latch_dependency_release_unit.sv
tb/tb_top.sv
